[rtl/pce_pkg.sv]
// ----------------------------------------------------------------------------
// pce_pkg
// Shared types and codes for the palette compaction run-length encoder.
// ----------------------------------------------------------------------------
package pce_pkg;

    // command codes carried in the slave-side tuser
    localparam logic [1:0] CMD_PALETTE = 2'd0;
    localparam logic [1:0] CMD_PIXEL   = 2'd1;
    localparam logic [1:0] CMD_DRAIN   = 2'd2;

    // register index, taken from paddr[2]
    localparam logic REG_MAX_COLORS = 1'b0;
    localparam logic REG_RUN_LIMIT  = 1'b1;

    localparam logic [8:0] MAX_COLORS_RST = 9'd20;
    localparam logic [7:0] RUN_LIMIT_RST  = 8'd255;

    typedef enum logic [9:0] {
        S_LOAD   = 10'b00_0000_0001,
        S_RANK   = 10'b00_0000_0010,
        S_EMIT   = 10'b00_0000_0100,
        S_PAL_W  = 10'b00_0000_1000,
        S_PAL_C  = 10'b00_0001_0000,
        S_SCAN_A = 10'b00_0010_0000,
        S_SCAN_F = 10'b00_0100_0000,
        S_SCAN_T = 10'b00_1000_0000,
        S_SCAN_W = 10'b01_0000_0000,
        S_SCAN_C = 10'b10_0000_0000
    } t_state;

    typedef enum logic [5:0] {
        PH_COUNT  = 6'b00_0001,
        PH_PAL    = 6'b00_0010,
        PH_RUNCNT = 6'b00_0100,
        PH_RUNVAL = 6'b00_1000,
        PH_ERROR  = 6'b01_0000,
        PH_ENDED  = 6'b10_0000
    } t_phase;

    // control toward the color tables
    typedef struct packed {
        logic        pal_we;
        logic [7:0]  pal_idx;
        logic [17:0] pal_rgb;
        logic        used_we;
        logic [7:0]  used_idx;
        logic        rank_we;
        logic [7:0]  rank_entry;
        logic [7:0]  rank_num;
        logic [7:0]  sweep_idx;
        logic [7:0]  rank_addr;
        logic [7:0]  newidx_addr;
    } t_ctab_ctl;

    // pixel value reduced modulo the palette size, for table building only
    function automatic logic [7:0] f_mod(input int unsigned v, input int unsigned p);
        int unsigned r;
        r = v;
        while (r >= p) begin
            r = r - p;
        end
        return 8'(r);
    endfunction

endpackage

[rtl/pce_frame_store.sv]
// ----------------------------------------------------------------------------
// pce_frame_store
// Frame memory: one write port for pixel loads, one registered read port.
// ----------------------------------------------------------------------------
module pce_frame_store #(
    parameter int FRAME_DEPTH = 65536,
    parameter int AW          = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [FRAME_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/pce_color_tables.sv]
// ----------------------------------------------------------------------------
// pce_color_tables
// Palette memory, used-color flags, new-index and rank-to-entry memories.
// ----------------------------------------------------------------------------
module pce_color_tables #(
    parameter int ENTRIES = 256,
    parameter int IDXW    = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pce_pkg::t_ctab_ctl i_ctl,
    output logic              o_used_bit,
    output logic [17:0]       o_pal_rgb,
    output logic              o_pal_ok,
    output logic [7:0]        o_newidx
);

    logic [17:0]       r_pal_mem    [ENTRIES];
    logic [7:0]        r_newidx_mem [ENTRIES];
    logic [IDXW-1:0]   r_rank_mem   [ENTRIES];
    logic [ENTRIES-1:0] r_pal_vld;
    logic [ENTRIES-1:0] r_used;
    logic              r_used_rd;
    logic [IDXW-1:0]   r_rank_rd;
    logic [17:0]       r_pal_rd;
    logic              r_pal_ok;
    logic [7:0]        r_newidx_rd;

    // flags cleared at reset; an unloaded palette entry reads with o_pal_ok low
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_vld <= '0;
            r_used    <= '0;
        end else begin
            if (i_ctl.pal_we) begin
                r_pal_vld[i_ctl.pal_idx[IDXW-1:0]] <= 1'b1;
            end
            if (i_ctl.used_we) begin
                r_used[i_ctl.used_idx[IDXW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.pal_we) begin
            r_pal_mem[i_ctl.pal_idx[IDXW-1:0]] <= i_ctl.pal_rgb;
        end
        if (i_ctl.rank_we) begin
            r_newidx_mem[i_ctl.rank_entry[IDXW-1:0]] <= i_ctl.rank_num;
            r_rank_mem[i_ctl.rank_num[IDXW-1:0]]     <= i_ctl.rank_entry[IDXW-1:0];
        end
        r_used_rd   <= r_used[i_ctl.sweep_idx[IDXW-1:0]];
        r_rank_rd   <= r_rank_mem[i_ctl.rank_addr[IDXW-1:0]];
        r_pal_rd    <= r_pal_mem[r_rank_rd];
        r_pal_ok    <= r_pal_vld[r_rank_rd];
        r_newidx_rd <= r_newidx_mem[i_ctl.newidx_addr[IDXW-1:0]];
    end

    assign o_used_bit = r_used_rd;
    assign o_pal_rgb  = r_pal_rd;
    assign o_pal_ok   = r_pal_ok;
    assign o_newidx   = r_newidx_rd;

endmodule

[rtl/palette_compact_rle_encoder.sv]
// ----------------------------------------------------------------------------
// palette_compact_rle_encoder
// Palette compaction of an indexed frame followed by a byte run-length stream.
// ----------------------------------------------------------------------------
// Palette and pixel loads are each taken on their own beat. The beat carrying
// tlast on a pixel load starts a rank sweep over the used-color flags, during
// which no beat is taken. Each drain beat then yields one output beat: count
// and run-value bytes directly, palette bytes after a rank memory read, then a
// palette memory read, and run-count bytes after a run scan that walks the
// frame memory read port one further pixel at a time, until the run stops at
// the limit, the frame end or a differing pixel. A new beat is taken once the
// output register is empty and the encoder is in its load or emit state. Only
// reset starts a new frame.
module palette_compact_rle_encoder #(
    parameter int FRAME_DEPTH     = 65536,
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // entry_index, red, green, blue, pixel
    input  logic        i_s_tlast,   // last_pixel
    input  logic [1:0]  i_s_tuser,   // cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // out_byte
    output logic        o_m_tlast,   // last_byte
    output logic [1:0]  o_m_tuser,   // too_many_colors, done_res
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PW   = $clog2(FRAME_DEPTH + 1);
    localparam int AW   = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int IDXW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    pce_pkg::t_state    r_state;
    pce_pkg::t_phase    r_phase;
    pce_pkg::t_ctab_ctl w_ctl;

    logic [8:0]    r_max;
    logic [7:0]    r_lim;
    logic [PW-1:0] r_pix_total;
    logic [PW-1:0] r_ptr;
    logic [8:0]    r_color_total;
    logic [8:0]    r_k;
    logic [8:0]    r_sweep;
    logic [8:0]    r_rank;
    logic [1:0]    r_comp;
    logic [AW-1:0] r_faddr;
    logic [7:0]    r_run_v;
    logic [7:0]    r_run_n;
    logic          r_ovalid;
    logic [7:0]    r_obyte;
    logic          r_olast;
    logic          r_oerr;
    logic          r_odone;

    logic [7:0]    w_mod_tbl [256];
    logic          w_s_acc;
    logic          w_cfg_wr;
    logic [1:0]    w_cmd;
    logic [7:0]    w_entry;
    logic [7:0]    w_pix;
    logic          w_pix_we;
    logic          w_used_bit;
    logic          w_used_hit;
    logic [8:0]    w_sweep_prev;
    logic [17:0]   w_pal_rgb;
    logic          w_pal_ok;
    logic [7:0]    w_newidx;
    logic [7:0]    w_frame_rd;
    logic [7:0]    w_eff_lim;
    logic [PW:0]   w_ptr_sum;
    logic [8:0]    w_k_next;
    logic [7:0]    w_comp_byte;

    for (genvar g = 0; g < 256; g++) begin : g_mod
        assign w_mod_tbl[g] = pce_pkg::f_mod(g, PALETTE_ENTRIES);
    end

    assign w_cmd    = i_s_tuser;
    assign w_entry  = i_s_tdata[7:0];
    assign w_pix    = w_mod_tbl[i_s_tdata[39:32]];
    assign w_s_acc  = i_s_tvalid && o_s_tready;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    assign o_s_tready = ((r_state == pce_pkg::S_LOAD) || (r_state == pce_pkg::S_EMIT))
                        && !r_ovalid;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == pce_pkg::REG_RUN_LIMIT) ? {24'd0, r_lim}
                                                              : {23'd0, r_max};

    assign w_pix_we  = w_s_acc && (r_state == pce_pkg::S_LOAD) &&
                       (w_cmd == pce_pkg::CMD_PIXEL) &&
                       (r_pix_total < PW'(FRAME_DEPTH));
    assign w_eff_lim = (r_lim == 8'd0) ? 8'd1 : r_lim;
    assign w_ptr_sum = {1'b0, r_ptr} + (PW + 1)'(r_run_n);
    // the flag read is registered: it belongs to the previous entry
    assign w_sweep_prev = r_sweep - 9'd1;
    assign w_used_hit   = w_used_bit && (r_sweep != 9'd0);
    assign w_k_next     = r_k + 9'(w_used_hit);

    always_comb begin
        unique case (r_comp)
            2'd0:    w_comp_byte = {2'b00, w_pal_rgb[17:12]};
            2'd1:    w_comp_byte = {2'b00, w_pal_rgb[11:6]};
            default: w_comp_byte = {2'b00, w_pal_rgb[5:0]};
        endcase
        if (!w_pal_ok) begin
            w_comp_byte = 8'd0;
        end
    end

    always_comb begin
        w_ctl             = '0;
        w_ctl.pal_we      = w_s_acc && (r_state == pce_pkg::S_LOAD) &&
                            (w_cmd == pce_pkg::CMD_PALETTE) &&
                            ({1'b0, w_entry} < 9'(PALETTE_ENTRIES));
        w_ctl.pal_idx     = w_entry;
        w_ctl.pal_rgb     = {i_s_tdata[15:10], i_s_tdata[23:18], i_s_tdata[31:26]};
        w_ctl.used_we     = w_pix_we;
        w_ctl.used_idx    = w_pix;
        w_ctl.rank_we     = (r_state == pce_pkg::S_RANK) && w_used_hit;
        w_ctl.rank_entry  = w_sweep_prev[7:0];
        w_ctl.rank_num    = r_k[7:0];
        w_ctl.sweep_idx   = r_sweep[7:0];
        w_ctl.rank_addr   = r_rank[7:0];
        w_ctl.newidx_addr = r_run_v;
    end

    pce_color_tables #(
        .ENTRIES (PALETTE_ENTRIES),
        .IDXW    (IDXW)
    ) u_tables (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .o_used_bit (w_used_bit),
        .o_pal_rgb  (w_pal_rgb),
        .o_pal_ok   (w_pal_ok),
        .o_newidx   (w_newidx)
    );

    pce_frame_store #(
        .FRAME_DEPTH (FRAME_DEPTH),
        .AW          (AW)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (w_pix_we),
        .i_waddr (r_pix_total[AW-1:0]),
        .i_wdata (w_pix),
        .i_raddr (r_faddr),
        .o_rdata (w_frame_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= pce_pkg::S_LOAD;
            r_phase       <= pce_pkg::PH_COUNT;
            r_max         <= pce_pkg::MAX_COLORS_RST;
            r_lim         <= pce_pkg::RUN_LIMIT_RST;
            r_pix_total   <= '0;
            r_ptr         <= '0;
            r_color_total <= '0;
            r_k           <= '0;
            r_sweep       <= '0;
            r_rank        <= '0;
            r_comp        <= '0;
            r_faddr       <= '0;
            r_ovalid      <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                if (paddr[2] == pce_pkg::REG_MAX_COLORS) begin
                    r_max <= pwdata[8:0];
                end else begin
                    r_lim <= pwdata[7:0];
                end
            end
            if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                pce_pkg::S_LOAD: begin
                    if (w_s_acc && (w_cmd == pce_pkg::CMD_PIXEL)) begin
                        if (w_pix_we) begin
                            r_pix_total <= r_pix_total + PW'(1);
                        end
                        if (i_s_tlast) begin
                            r_sweep <= '0;
                            r_k     <= '0;
                            r_state <= pce_pkg::S_RANK;
                        end
                    end
                end
                pce_pkg::S_RANK: begin
                    r_k     <= w_k_next;
                    r_sweep <= r_sweep + 9'd1;
                    if (r_sweep == 9'(PALETTE_ENTRIES)) begin
                        r_color_total <= w_k_next;
                        r_ptr         <= '0;
                        r_phase       <= (w_k_next > r_max) ? pce_pkg::PH_ERROR
                                                            : pce_pkg::PH_COUNT;
                        r_state       <= pce_pkg::S_EMIT;
                    end
                end
                pce_pkg::S_EMIT: begin
                    if (w_s_acc && (w_cmd == pce_pkg::CMD_DRAIN)) begin
                        unique case (r_phase)
                            pce_pkg::PH_COUNT: begin
                                r_ovalid <= 1'b1;
                                r_obyte  <= r_color_total[7:0];
                                r_olast  <= 1'b0;
                                r_oerr   <= 1'b0;
                                r_odone  <= 1'b0;
                                r_rank   <= '0;
                                r_comp   <= '0;
                                r_ptr    <= '0;
                                r_phase  <= (r_color_total != 9'd0) ? pce_pkg::PH_PAL
                                                                    : pce_pkg::PH_RUNCNT;
                            end
                            pce_pkg::PH_PAL: begin
                                r_state <= pce_pkg::S_PAL_W;
                            end
                            pce_pkg::PH_RUNCNT: begin
                                r_faddr <= r_ptr[AW-1:0];
                                r_state <= pce_pkg::S_SCAN_A;
                            end
                            pce_pkg::PH_RUNVAL: begin
                                r_ovalid <= 1'b1;
                                r_obyte  <= w_newidx;
                                r_olast  <= (w_ptr_sum >= {1'b0, r_pix_total});
                                r_oerr   <= 1'b0;
                                r_odone  <= 1'b0;
                                r_ptr    <= w_ptr_sum[PW-1:0];
                                r_phase  <= (w_ptr_sum >= {1'b0, r_pix_total})
                                            ? pce_pkg::PH_ENDED : pce_pkg::PH_RUNCNT;
                            end
                            pce_pkg::PH_ERROR: begin
                                r_ovalid <= 1'b1;
                                r_obyte  <= 8'd0;
                                r_olast  <= 1'b1;
                                r_oerr   <= 1'b1;
                                r_odone  <= 1'b0;
                                r_phase  <= pce_pkg::PH_ENDED;
                            end
                            default: begin
                                r_ovalid <= 1'b1;
                                r_obyte  <= 8'd0;
                                r_olast  <= 1'b0;
                                r_oerr   <= 1'b0;
                                r_odone  <= 1'b1;
                            end
                        endcase
                    end
                end
                pce_pkg::S_PAL_W: begin
                    r_state <= pce_pkg::S_PAL_C;
                end
                pce_pkg::S_PAL_C: begin
                    r_ovalid <= 1'b1;
                    r_obyte  <= w_comp_byte;
                    r_olast  <= 1'b0;
                    r_oerr   <= 1'b0;
                    r_odone  <= 1'b0;
                    if (r_comp == 2'd2) begin
                        r_comp <= 2'd0;
                        r_rank <= r_rank + 9'd1;
                        if ((r_rank + 9'd1) == r_color_total) begin
                            r_ptr   <= '0;
                            r_phase <= pce_pkg::PH_RUNCNT;
                        end
                    end else begin
                        r_comp <= r_comp + 2'd1;
                    end
                    r_state <= pce_pkg::S_EMIT;
                end
                pce_pkg::S_SCAN_A: begin
                    r_state <= pce_pkg::S_SCAN_F;
                end
                pce_pkg::S_SCAN_F: begin
                    r_run_v <= w_frame_rd;
                    r_run_n <= 8'd1;
                    r_state <= pce_pkg::S_SCAN_T;
                end
                pce_pkg::S_SCAN_T: begin
                    // extend the run while under the limit and inside the frame
                    if ((r_run_n < w_eff_lim) && (w_ptr_sum < {1'b0, r_pix_total})) begin
                        r_faddr <= w_ptr_sum[AW-1:0];
                        r_state <= pce_pkg::S_SCAN_W;
                    end else begin
                        r_ovalid <= 1'b1;
                        r_obyte  <= r_run_n;
                        r_olast  <= 1'b0;
                        r_oerr   <= 1'b0;
                        r_odone  <= 1'b0;
                        r_phase  <= pce_pkg::PH_RUNVAL;
                        r_state  <= pce_pkg::S_EMIT;
                    end
                end
                pce_pkg::S_SCAN_W: begin
                    r_state <= pce_pkg::S_SCAN_C;
                end
                pce_pkg::S_SCAN_C: begin
                    if (w_frame_rd == r_run_v) begin
                        r_run_n <= r_run_n + 8'd1;
                        r_state <= pce_pkg::S_SCAN_T;
                    end else begin
                        r_ovalid <= 1'b1;
                        r_obyte  <= r_run_n;
                        r_olast  <= 1'b0;
                        r_oerr   <= 1'b0;
                        r_odone  <= 1'b0;
                        r_phase  <= pce_pkg::PH_RUNVAL;
                        r_state  <= pce_pkg::S_EMIT;
                    end
                end
                default: begin
                    r_state <= pce_pkg::S_LOAD;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_obyte;
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = {r_odone, r_oerr};

    a_no_take_while_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("input beat taken while an output beat is pending");

    a_color_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_color_total <= 9'(PALETTE_ENTRIES))
        else $error("color total beyond palette size");

    a_done_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> (!o_m_tlast && !o_m_tuser[0]))
        else $error("done beat carries last or error");

    a_err_ends_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tlast && (r_phase == pce_pkg::PH_ENDED)))
        else $error("error beat does not end the stream");

    a_rank_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pce_pkg::S_RANK) |-> !o_s_tready)
        else $error("beat accepted during rank sweep");

endmodule
